>>> hw/rtl/pse_pkg.sv
// shared types and constants of the postfix stack evaluator
`default_nettype none
package pse_pkg;

  // expression byte codes
  localparam logic [7:0] SYM_ADD  = 8'h2B;
  localparam logic [7:0] SYM_SUB  = 8'h2D;
  localparam logic [7:0] SYM_MUL  = 8'h2A;
  localparam logic [7:0] SYM_DIV  = 8'h2F;
  localparam logic [8:0] SYM_ZERO = 9'h030;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [1:0] ST_DIVZERO   = 2'd2;
  localparam logic [1:0] ST_OVERFLOW  = 2'd3;

  // decoupling queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  typedef enum logic [2:0] {
    OP_PUSH,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } op_t;

  // one classified byte as it travels through the queue
  typedef struct packed {
    op_t        op;
    logic [8:0] operand;  // byte minus '0', signed
    logic       last;
  } entry_t;

endpackage
`default_nettype wire

>>> hw/rtl/pse_front.sv
// front end: accepts expression bytes and classifies them into queue entries
`default_nettype none
module pse_front (
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [7:0]      in_symbol,
  input  wire logic            in_last,
  input  wire logic            q_full,
  output logic                 q_push,
  output pse_pkg::entry_t      q_data
);
  import pse_pkg::*;

  // accept whenever the queue has room
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // decode operator bytes, everything else is an operand
  always_comb begin
    q_data.last    = in_last;
    q_data.operand = {1'b0, in_symbol} - SYM_ZERO;
    case (in_symbol)
      SYM_ADD: q_data.op = OP_ADD;
      SYM_SUB: q_data.op = OP_SUB;
      SYM_MUL: q_data.op = OP_MUL;
      SYM_DIV: q_data.op = OP_DIV;
      default: q_data.op = OP_PUSH;
    endcase
  end

endmodule
`default_nettype wire

>>> hw/rtl/pse_queue.sv
// small fifo of classified bytes between front and back
`default_nettype none
module pse_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire pse_pkg::entry_t push_data,
  output logic                 full,
  input  wire logic            pop,
  output logic                 empty,
  output pse_pkg::entry_t      pop_data
);
  import pse_pkg::*;

  entry_t          slot_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]   count_r, count_nxt;

  assign full     = (count_r == (Q_AW+1)'(Q_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = slot_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/pse_div.sv
// iterative signed divider, one quotient bit per cycle, truncating toward zero
`default_nettype none
module pse_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [31:0]      quotient
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  step_r, step_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic        neg_r, neg_nxt;
  logic [32:0] shifted;
  logic [32:0] diff;

  assign done     = done_r;
  assign quotient = neg_r ? (32'd0 - quo_r) : quo_r;

  // restoring step on magnitudes
  always_comb begin
    shifted  = {rem_r, quo_r[31]};
    diff     = shifted - {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend[31] ? (32'd0 - dividend) : dividend;
      dvs_nxt  = divisor[31] ? (32'd0 - divisor) : divisor;
      neg_nxt  = dividend[31] ^ divisor[31];
    end else if (busy_r) begin
      if (!diff[32]) begin
        rem_nxt = diff[31:0];
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = shifted[31:0];
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      step_nxt = step_r + 1'b1;
      if (step_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    dvs_r  <= dvs_nxt;
    neg_r  <= neg_nxt;
  end

endmodule
`default_nettype wire

>>> hw/rtl/pse_back.sv
// back end: operand stack, arithmetic, divider control and result register
`default_nettype none
module pse_back #(
  parameter int STACK_DEPTH = 128
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  input  wire pse_pkg::entry_t    q_data,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_value,
  output logic [1:0]              out_status
);
  import pse_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(STACK_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_DIV,
    S_FIN
  } state_t;

  state_t         state_r, state_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [1:0]     err_r, err_nxt;
  logic [31:0]    tos_r, tos_nxt;
  op_t            op_r, op_nxt;
  logic           last_r, last_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [31:0]    out_value_r, out_value_nxt;
  logic [1:0]     out_status_r, out_status_nxt;
  logic [1:0]     fin_status;

  // stack memory below the top-of-stack register
  logic [31:0]    mem [STACK_DEPTH];
  logic [31:0]    rd_data_r;
  logic           mem_we, mem_re;
  logic [AW-1:0]  mem_waddr, mem_raddr;

  logic [31:0]    res;
  logic [31:0]    prod;
  logic           div_start, div_done;
  logic [31:0]    div_q;

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

  assign mem_waddr = AW'(cnt_r - 1'b1);
  assign mem_raddr = AW'(cnt_r - CW'(2));
  assign prod      = rd_data_r * tos_r;

  // first error of an expression sticks
  function automatic logic [1:0] note_err(input logic [1:0] cur, input logic [1:0] code);
    note_err = (cur == ST_OK) ? code : cur;
  endfunction

  pse_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rd_data_r),
    .divisor  (tos_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // sequencer for one byte per visit to idle
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    err_nxt        = err_r;
    tos_nxt        = tos_r;
    op_nxt         = op_r;
    last_nxt       = last_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    q_pop          = 1'b0;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    div_start      = 1'b0;
    res            = '0;
    fin_status     = (err_r == ST_OK && cnt_r == '0) ? ST_UNDERFLOW : err_r;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          op_nxt   = q_data.op;
          last_nxt = q_data.last;
          if (q_data.op == OP_PUSH) begin
            if (cnt_r == FULL_CNT) begin
              err_nxt = note_err(err_r, ST_OVERFLOW);
            end else begin
              mem_we  = (cnt_r != '0);
              tos_nxt = {{23{q_data.operand[8]}}, q_data.operand};
              cnt_nxt = cnt_r + 1'b1;
            end
            state_nxt = q_data.last ? S_FIN : S_IDLE;
          end else if (cnt_r < CW'(2)) begin
            err_nxt   = note_err(err_r, ST_UNDERFLOW);
            state_nxt = q_data.last ? S_FIN : S_IDLE;
          end else begin
            mem_re    = 1'b1;
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        case (op_r)
          OP_ADD: res = rd_data_r + tos_r;
          OP_SUB: res = rd_data_r - tos_r;
          OP_MUL: res = prod;
          default: begin
            if (tos_r == '0) begin
              err_nxt = note_err(err_r, ST_DIVZERO);
              res     = '0;
            end else begin
              div_start = 1'b1;
            end
          end
        endcase
        if (op_r == OP_DIV && tos_r != '0) begin
          state_nxt = S_DIV;
        end else begin
          tos_nxt   = res;
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = last_r ? S_FIN : S_IDLE;
        end
      end
      S_DIV: begin
        if (div_done) begin
          tos_nxt   = div_q;
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = last_r ? S_FIN : S_IDLE;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = fin_status;
          out_value_nxt  = (fin_status == ST_UNDERFLOW) ? '0 : tos_r;
          cnt_nxt        = '0;
          err_nxt        = ST_OK;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      err_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
    tos_r        <= tos_nxt;
    op_r         <= op_nxt;
    last_r       <= last_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  // stack memory ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= tos_r;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/postfix_stack_evaluator_core.sv
// top level of the postfix stack evaluator
//
// Input channel (in_valid/in_ready, in_symbol, in_last) takes one expression
// byte per transaction; in_last marks the final byte. Operator bytes + - * /
// combine the two top stack values, any other byte pushes its code minus '0'.
// Output channel (out_valid/out_ready, out_value, out_status) carries one
// transaction per expression: the final top of stack and its status.
// Bytes pass a front decoder and a four-entry queue to the back end, which
// holds the top of stack in a register and the rest in a single-port memory.
// Back-end steps per byte: a push is taken in idle; + - * go from idle,
// which issues one memory read of the second operand, to the compute
// state; / also waits in the divide state for the bit-serial divider,
// unless the divisor is zero. An operator that finds fewer than two values
// is handled in idle alone. The last byte then passes the finish state,
// which loads the result register.
// While the receiver stalls, the result stays in the output register and the
// front keeps filling the queue until it is full.
// Reset empties the queue and the stack and clears the error; no clearing
// pass is needed, the stack memory is only read below the fill count.
`default_nettype none
module postfix_stack_evaluator_core #(
  parameter int STACK_DEPTH = 128
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         in_symbol,
  input  wire logic               in_last,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_value,
  output logic [1:0]              out_status
);
  import pse_pkg::*;

  entry_t front_data;
  entry_t back_data;
  logic   q_push, q_pop, q_full, q_empty;

  pse_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_symbol (in_symbol),
    .in_last   (in_last),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (front_data)
  );

  pse_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (front_data),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_data  (back_data)
  );

  pse_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (!q_empty),
    .q_data     (back_data),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_value  (out_value),
    .out_status (out_status)
  );

  // underflow results always carry zero
  a_underflow_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_UNDERFLOW) |-> (out_value == 32'sd0))
    else $error("underflow result with nonzero value");

  // back end never takes from an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule
`default_nettype wire
